@@ sv/tlik_pkg.sv @@
`default_nettype none

package tlik_pkg;

	// Register indexes, decoded from the word address of the configuration port.
	localparam logic REG_UPPER = 1'b0;
	localparam logic REG_LOWER = 1'b1;

	localparam logic [13:0] LINK_RESET = 14'd6356;

	// Angles inside the datapath are in units of 2^-30 rad.
	localparam logic [31:0] Q30_PI      = 32'd3373259426;
	localparam logic [30:0] Q30_HALF_PI = 31'd1686629713;

	localparam int ATAN_LEN = 24;

	// Vectoring unit operand width and the number of stages ahead of its rotations.
	localparam int VEC_W   = 44;
	localparam int VEC_PRE = 2;

	// Square root: a 58-bit radicand gives a 29-bit root, one root bit per stage.
	localparam int SQ_IN_W  = 58;
	localparam int SQ_OUT_W = 29;

	function automatic logic [29:0] atan_q30(input int unsigned i);
		logic [29:0] v;
		unique case (i)
			0:  v = 30'd843314856;
			1:  v = 30'd497837829;
			2:  v = 30'd263043836;
			3:  v = 30'd133525158;
			4:  v = 30'd67021686;
			5:  v = 30'd33543515;
			6:  v = 30'd16775850;
			7:  v = 30'd8388437;
			8:  v = 30'd4194282;
			9:  v = 30'd2097149;
			10: v = 30'd1048575;
			11: v = 30'd524287;
			12: v = 30'd262143;
			13: v = 30'd131071;
			14: v = 30'd65535;
			15: v = 30'd32767;
			16: v = 30'd16383;
			17: v = 30'd8191;
			18: v = 30'd4095;
			19: v = 30'd2047;
			20: v = 30'd1023;
			21: v = 30'd511;
			22: v = 30'd255;
			23: v = 30'd127;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

@@ sv/tlik_target_if.sv @@
`default_nettype none

interface tlik_target_if;
	logic               valid;
	logic               ready;
	logic signed [14:0] target_x;
	logic signed [14:0] target_y;
	logic signed [14:0] target_z;

	modport source(output valid, output target_x, output target_y, output target_z,
		input ready);
	modport sink(input valid, input target_x, input target_y, input target_z,
		output ready);
endinterface

`default_nettype wire

@@ sv/tlik_result_if.sv @@
`default_nettype none

interface tlik_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] shoulder_angle;
	logic        [13:0] elbow_angle;
	logic signed [15:0] wrist_angle;
	logic               out_of_reach;

	modport source(output valid, output shoulder_angle, output elbow_angle,
		output wrist_angle, output out_of_reach, input ready);
	modport sink(input valid, input shoulder_angle, input elbow_angle,
		input wrist_angle, input out_of_reach, output ready);
endinterface

`default_nettype wire

@@ sv/tlik_isqrt.sv @@
`default_nettype none

module tlik_isqrt (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [tlik_pkg::SQ_IN_W-1:0]  rad,
	output logic      [tlik_pkg::SQ_OUT_W-1:0] root
);
	import tlik_pkg::*;

	logic [SQ_IN_W-1:0]  rad_s  [SQ_OUT_W];
	logic [SQ_OUT_W-1:0] root_s [SQ_OUT_W];
	logic [SQ_OUT_W:0]   rem_s  [SQ_OUT_W];

	// Restoring square root: each stage brings down two radicand bits and decides one root bit.
	for (genvar i = 0; i < SQ_OUT_W; i++) begin : g_step
		logic [SQ_IN_W-1:0]  rad_in;
		logic [SQ_OUT_W-1:0] root_in;
		logic [SQ_OUT_W:0]   rem_in;
		logic [SQ_OUT_W+2:0] cur;
		logic [SQ_OUT_W+2:0] trial;
		logic [SQ_OUT_W+2:0] diff;
		logic                ge;

		if (i == 0) begin : g_first
			assign rad_in  = rad;
			assign root_in = '0;
			assign rem_in  = '0;
		end else begin : g_next
			assign rad_in  = rad_s[i-1];
			assign root_in = root_s[i-1];
			assign rem_in  = rem_s[i-1];
		end

		assign cur   = {rem_in, rad_in[SQ_IN_W-1 -: 2]};
		assign trial = {1'b0, root_in, 2'b01};
		assign ge    = cur >= trial;
		assign diff  = cur - trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[i]  <= rad_in << 2;
				root_s[i] <= {root_in[SQ_OUT_W-2:0], ge};
				rem_s[i]  <= ge ? diff[SQ_OUT_W:0] : cur[SQ_OUT_W:0];
			end
		end
	end

	assign root = root_s[SQ_OUT_W-1];

endmodule

`default_nettype wire

@@ sv/tlik_vec.sv @@
`default_nettype none

module tlik_vec #(
	parameter int STAGES = 16
) (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic [tlik_pkg::VEC_W-1:0] px,
	input  wire logic [tlik_pkg::VEC_W-1:0] py,
	output logic      [30:0]                angle
);
	import tlik_pkg::*;

	logic [VEC_W-1:0] m;
	logic [5:0]       pos;
	logic [VEC_W-1:0] px_s1, py_s1;
	logic [5:0]       pos_s1;
	logic             zero_s1;
	logic [VEC_W-1:0] xs, ys;
	logic [29:0]      x_s2, y_s2;
	logic             zero_s2;

	logic signed [32:0] cx_s [STAGES];
	logic signed [32:0] cy_s [STAGES];
	logic signed [32:0] cz_s [STAGES];
	logic               zero_s [STAGES];
	logic signed [32:0] z_fin;

	// Leading one of the larger operand sets the normalizing shift.
	always_comb begin
		m   = (px > py) ? px : py;
		pos = '0;
		for (int b = 0; b < VEC_W; b++) begin
			if (m[b]) pos = 6'(b);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1   <= px;
			py_s1   <= py;
			pos_s1  <= pos;
			zero_s1 <= (m == '0);
		end
	end

	// Bring the larger operand into [2^29, 2^30).
	always_comb begin
		if (pos_s1 >= 6'd29) begin
			xs = px_s1 >> (pos_s1 - 6'd29);
			ys = py_s1 >> (pos_s1 - 6'd29);
		end else begin
			xs = px_s1 << (6'd29 - pos_s1);
			ys = py_s1 << (6'd29 - pos_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2    <= xs[29:0];
			y_s2    <= ys[29:0];
			zero_s2 <= zero_s1;
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_rot
		logic signed [32:0] xi, yi, zi, dx, dy, at;
		logic               zf;

		if (i == 0) begin : g_first
			assign xi = $signed({3'b000, x_s2});
			assign yi = $signed({3'b000, y_s2});
			assign zi = '0;
			assign zf = zero_s2;
		end else begin : g_next
			assign xi = cx_s[i-1];
			assign yi = cy_s[i-1];
			assign zi = cz_s[i-1];
			assign zf = zero_s[i-1];
		end

		assign dx = yi >>> i;
		assign dy = xi >>> i;
		assign at = $signed({3'b000, atan_q30(i)});

		always_ff @(posedge clk) begin
			if (en) begin
				if (yi < 0) begin
					cx_s[i] <= xi - dx;
					cy_s[i] <= yi + dy;
					cz_s[i] <= zi - at;
				end else begin
					cx_s[i] <= xi + dx;
					cy_s[i] <= yi - dy;
					cz_s[i] <= zi + at;
				end
				zero_s[i] <= zf;
			end
		end
	end

	assign z_fin = cz_s[STAGES-1];

	always_comb begin
		priority if (zero_s[STAGES-1] || z_fin < 0) begin
			angle = '0;
		end else if (z_fin > $signed({2'b00, Q30_HALF_PI})) begin
			angle = Q30_HALF_PI;
		end else begin
			angle = z_fin[30:0];
		end
	end

endmodule

`default_nettype wire

@@ sv/two_link_arm_inverse_kinematics.sv @@
// Channel   Dir  Payload                                                 Handshake
// target    in   target_x, target_y, target_z (15 b signed each)         valid / ready
// result    out  shoulder_angle, elbow_angle, wrist_angle, out_of_reach   valid / ready
// apb       in   upper_link_length (0x0), lower_link_length (0x4)        psel / penable
//
// One item enters per cycle while no result is stalled; the pipeline runs through the
// 29-stage square root and the rotation stages of the vectoring units.
// A stalled result holds the whole pipeline in place; target.ready is low only then.
// Reset clears the valid bits and sets both link lengths to 6356.
`default_nettype none

module two_link_arm_inverse_kinematics #(
	parameter int CORDIC_STAGES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	tlik_target_if.sink      target,
	tlik_result_if.source    result
);
	import tlik_pkg::*;

	localparam int VEC_LAT = VEC_PRE + CORDIC_STAGES;

	typedef struct packed {
		logic        vld;
		logic        oor;
		logic        num_neg;
		logic        y_neg;
		logic        d2_neg;
		logic [28:0] an;
		logic [14:0] ay;
		logic [43:0] ad2;
	} side_t;

	typedef struct packed {
		logic vld;
		logic oor;
		logic num_neg;
		logic y_neg;
		logic d2_neg;
	} flag_t;

	logic [13:0] upper_q, lower_q;
	logic        en;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= LINK_RESET;
			lower_q <= LINK_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_UPPER) upper_q <= pwdata[13:0];
			else                       lower_q <= pwdata[13:0];
		end
	end

	assign prdata = (paddr[2] == REG_LOWER) ? {18'b0, lower_q} : {18'b0, upper_q};
	assign pready = 1'b1;

	// Stage 1: squares.
	logic signed [29:0] xsq, ysq, zsq;
	logic        [27:0] l11, l22, l12;
	logic        [14:0] ay_c;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [28:0] xx_s1, yy_s1, zz_s1;
	logic [27:0] l11_s1, l22_s1, l12_s1;
	logic        y_neg_s1, y_neg_s2, y_neg_s3, y_neg_s4, y_neg_s5;
	logic [14:0] ay_s1, ay_s2, ay_s3, ay_s4, ay_s5;

	assign xsq  = target.target_x * target.target_x;
	assign ysq  = target.target_y * target.target_y;
	assign zsq  = target.target_z * target.target_z;
	assign l11  = upper_q * upper_q;
	assign l22  = lower_q * lower_q;
	assign l12  = upper_q * lower_q;
	assign ay_c = target.target_y[14] ? 15'(-target.target_y) : target.target_y;

	// Stage 2: numerator and denominator of the elbow cosine.
	logic signed [31:0] num_s2, num_s3;
	logic        [28:0] den_s2, den_s3;
	logic        [29:0] hxz_s2, hxz_s3, hxz_s4, hxz_s5;

	// Stage 3: reach test and the shift that lifts the denominator to 2^28.
	logic        oor_c;
	logic [4:0]  k_c;
	logic        oor_s3, oor_s4, oor_s5;
	logic [4:0]  k_s3;

	always_comb begin
		oor_c = (den_s2 == '0) || (num_s2 > $signed({3'b000, den_s2}))
			|| (num_s2 < -$signed({3'b000, den_s2}));
		k_c = '0;
		for (int b = 0; b < 29; b++) begin
			if (den_s2[b]) k_c = 5'(28 - b);
		end
	end

	// Stage 4: scaled operands.
	logic signed [31:0] num_sh;
	logic        [29:0] an_c;
	logic signed [29:0] num_n_s4;
	logic        [28:0] den_n_s4, an_s4, an_s5;
	logic               num_neg_s4, num_neg_s5;

	assign num_sh = num_s3 <<< k_s3;
	assign an_c   = num_sh[31] ? 30'(-num_sh) : num_sh[29:0];

	// Stage 5: products for the sine and the correction angle.
	logic        [57:0] den2_s5, an2_s5;
	logic        [42:0] p1_s5;
	logic signed [44:0] p2_s5;

	// Stage 6: radicands and the sign of the correction denominator.
	logic signed [44:0] d2_c;
	side_t              side_c, side_s6;
	logic        [57:0] rad_e_s6, rad_h_s6;

	assign d2_c = $signed({2'b00, p1_s5}) + p2_s5;

	always_comb begin
		side_c.vld     = vld_s5;
		side_c.oor     = oor_s5;
		side_c.num_neg = num_neg_s5;
		side_c.y_neg   = y_neg_s5;
		side_c.d2_neg  = d2_c[44];
		side_c.an      = an_s5;
		side_c.ay      = ay_s5;
		side_c.ad2     = d2_c[44] ? 44'(-d2_c) : d2_c[43:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= target.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1    <= xsq[28:0];
			yy_s1    <= ysq[28:0];
			zz_s1    <= zsq[28:0];
			l11_s1   <= l11;
			l22_s1   <= l22;
			l12_s1   <= l12;
			y_neg_s1 <= target.target_y[14];
			ay_s1    <= ay_c;

			num_s2   <= $signed({3'b000, xx_s1} + {3'b000, yy_s1} + {3'b000, zz_s1})
				- $signed({4'b0000, l11_s1} + {4'b0000, l22_s1});
			den_s2   <= {l12_s1, 1'b0};
			hxz_s2   <= {1'b0, xx_s1} + {1'b0, zz_s1};
			y_neg_s2 <= y_neg_s1;
			ay_s2    <= ay_s1;

			oor_s3   <= oor_c;
			k_s3     <= k_c;
			num_s3   <= num_s2;
			den_s3   <= den_s2;
			hxz_s3   <= hxz_s2;
			y_neg_s3 <= y_neg_s2;
			ay_s3    <= ay_s2;

			den_n_s4   <= den_s3 << k_s3;
			num_n_s4   <= num_sh[29:0];
			an_s4      <= an_c[28:0];
			num_neg_s4 <= num_sh[31];
			oor_s4     <= oor_s3;
			hxz_s4     <= hxz_s3;
			y_neg_s4   <= y_neg_s3;
			ay_s4      <= ay_s3;

			den2_s5    <= den_n_s4 * den_n_s4;
			an2_s5     <= an_s4 * an_s4;
			p1_s5      <= upper_q * den_n_s4;
			p2_s5      <= $signed({1'b0, lower_q}) * num_n_s4;
			an_s5      <= an_s4;
			num_neg_s5 <= num_neg_s4;
			oor_s5     <= oor_s4;
			hxz_s5     <= hxz_s4;
			y_neg_s5   <= y_neg_s4;
			ay_s5      <= ay_s4;

			rad_e_s6 <= den2_s5 - an2_s5;
			rad_h_s6 <= {hxz_s5, 28'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s6 <= '0;
		end else if (en) begin
			side_s6 <= side_c;
		end
	end

	// Square roots: the sine of the elbow and the horizontal distance.
	logic [SQ_OUT_W-1:0] sin_root, hor_root;
	side_t               sd_s [SQ_OUT_W];

	tlik_isqrt u_sqrt_sin (
		.clk  (clk),
		.en   (en),
		.rad  (rad_e_s6),
		.root (sin_root)
	);

	tlik_isqrt u_sqrt_hor (
		.clk  (clk),
		.en   (en),
		.rad  (rad_h_s6),
		.root (hor_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SQ_OUT_W; i++) sd_s[i] <= '0;
		end else if (en) begin
			sd_s[0] <= side_s6;
			for (int i = 1; i < SQ_OUT_W; i++) sd_s[i] <= sd_s[i-1];
		end
	end

	// Stage 7: scale the sine by the second link.
	side_t       side_s7;
	logic [28:0] s_s7, h_s7;
	logic [42:0] ls_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) side_s7 <= '0;
		else if (en) side_s7 <= sd_s[SQ_OUT_W-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s7  <= sin_root;
			h_s7  <= hor_root;
			ls_s7 <= lower_q * sin_root;
		end
	end

	// Three vectoring units in parallel.
	logic [30:0] elbow_v, elev_v, corr_v;
	flag_t       fl_c;
	flag_t       vd_s [VEC_LAT];

	tlik_vec #(.STAGES(CORDIC_STAGES)) u_vec_elbow (
		.clk   (clk),
		.en    (en),
		.px    ({15'b0, side_s7.an}),
		.py    ({15'b0, s_s7}),
		.angle (elbow_v)
	);

	tlik_vec #(.STAGES(CORDIC_STAGES)) u_vec_elev (
		.clk   (clk),
		.en    (en),
		.px    ({15'b0, h_s7}),
		.py    ({15'b0, side_s7.ay, 14'b0}),
		.angle (elev_v)
	);

	tlik_vec #(.STAGES(CORDIC_STAGES)) u_vec_corr (
		.clk   (clk),
		.en    (en),
		.px    (side_s7.ad2),
		.py    ({1'b0, ls_s7}),
		.angle (corr_v)
	);

	assign fl_c = '{vld: side_s7.vld, oor: side_s7.oor, num_neg: side_s7.num_neg,
		y_neg: side_s7.y_neg, d2_neg: side_s7.d2_neg};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VEC_LAT; i++) vd_s[i] <= '0;
		end else if (en) begin
			vd_s[0] <= fl_c;
			for (int i = 1; i < VEC_LAT; i++) vd_s[i] <= vd_s[i-1];
		end
	end

	// Stage 8: signed joint terms and the shoulder.
	flag_t              fl_v;
	logic signed [35:0] elbow_c, elev_c, corr_c;
	logic signed [35:0] elbow_s8, shoulder_s8;
	logic               vld_s8, oor_s8;

	assign fl_v = vd_s[VEC_LAT-1];

	always_comb begin
		elbow_c = fl_v.num_neg ? $signed({4'b0, Q30_PI}) - $signed({5'b0, elbow_v})
			: $signed({5'b0, elbow_v});
		elev_c  = fl_v.y_neg ? -$signed({5'b0, elev_v}) : $signed({5'b0, elev_v});
		corr_c  = fl_v.d2_neg ? -$signed({5'b0, corr_v}) : $signed({5'b0, corr_v});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s8 <= 1'b0;
		else if (en) vld_s8 <= fl_v.vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			elbow_s8    <= elbow_c;
			shoulder_s8 <= $signed({5'b0, Q30_HALF_PI}) - elev_c - corr_c;
			oor_s8      <= fl_v.oor;
		end
	end

	// Output stage: wrist, rounding to 2^-12 rad, and the out-of-reach result.
	function automatic logic signed [35:0] round12(input logic signed [35:0] q);
		return (q + 36'sd131072) >>> 18;
	endfunction

	logic signed [35:0] wrist_c, sh_r, el_r, wr_r;
	logic               vld_q;
	logic signed [15:0] shoulder_q, wrist_q;
	logic        [13:0] elbow_q;
	logic               oor_q;

	assign wrist_c = $signed({4'b0, Q30_PI}) - (elbow_s8 + shoulder_s8);
	assign sh_r    = round12(shoulder_s8);
	assign el_r    = round12(elbow_s8);
	assign wr_r    = round12(wrist_c);

	assign en = !vld_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (en) vld_q <= vld_s8;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oor_q <= oor_s8;
			if (oor_s8) begin
				shoulder_q <= '0;
				elbow_q    <= '0;
				wrist_q    <= '0;
			end else begin
				shoulder_q <= sh_r[15:0];
				elbow_q    <= el_r[13:0];
				wrist_q    <= wr_r[15:0];
			end
		end
	end

	assign target.ready          = en;
	assign result.valid          = vld_q;
	assign result.shoulder_angle = shoulder_q;
	assign result.elbow_angle    = elbow_q;
	assign result.wrist_angle    = wrist_q;
	assign result.out_of_reach   = oor_q;

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.out_of_reach |->
			result.shoulder_angle == 16'sd0 && result.elbow_angle == 14'd0
			&& result.wrist_angle == 16'sd0)
		else $error("out-of-reach result carries nonzero angles");

	a_elbow_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.out_of_reach |-> result.elbow_angle <= 14'd12868)
		else $error("elbow angle beyond pi");

	a_busy_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!target.ready |-> result.valid && !result.ready)
		else $error("input refused without a stalled result");

	a_zero_link: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_s2 && den_s2 == '0 |=> oor_s3)
		else $error("zero link length not flagged out of reach");

endmodule

`default_nettype wire

@@ sim/two_link_arm_inverse_kinematics_test.sv @@
`timescale 1ns / 1ps

module two_link_arm_inverse_kinematics_test;
	import tlik_pkg::*;

	localparam int STAGES    = 16;
	localparam int MAX_CYCLE = 400000;
	localparam logic [2:0] ADDR_UPPER = 3'(REG_UPPER) << 2;
	localparam logic [2:0] ADDR_LOWER = 3'(REG_LOWER) << 2;

	typedef struct {
		logic signed [14:0] x;
		logic signed [14:0] y;
		logic signed [14:0] z;
	} target_t;

	typedef struct {
		logic signed [15:0] shoulder;
		logic        [13:0] elbow;
		logic signed [15:0] wrist;
		logic               unreachable;
	} angles_t;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	tlik_target_if tgt();
	tlik_result_if res();

	two_link_arm_inverse_kinematics #(.CORDIC_STAGES(STAGES)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.target(tgt), .result(res)
	);

	target_t pending_q[$];
	angles_t angles_q[$];
	logic [13:0] upper_len, lower_len;
	int errors, checked, reach_cnt, cycle;
	bit target_took, steady, want_hold;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle++;
		if (cycle > MAX_CYCLE) begin
			$display("timeout at %0t, %0d results outstanding", $time, angles_q.size());
			$display("** two_link_arm_inverse_kinematics: FAILED **");
			$finish;
		end
	end

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	// Angle of a first-quadrant vector in 2^-30 rad.
	function automatic longint vector_angle(longint unsigned px, longint unsigned py);
		longint unsigned m;
		longint vx, vy, acc, dx, dy;
		m = px > py ? px : py;
		if (m == 0) return 0;
		while (m >= (64'd1 << 30)) begin
			px >>= 1; py >>= 1; m >>= 1;
		end
		while (m < (64'd1 << 29)) begin
			px <<= 1; py <<= 1; m <<= 1;
		end
		vx = longint'(px);
		vy = longint'(py);
		acc = 0;
		for (int i = 0; i < STAGES && i < ATAN_LEN; i++) begin
			dx = vy >>> i;
			dy = vx >>> i;
			if (vy < 0) begin
				vx -= dx; vy += dy; acc -= longint'(atan_q30(i));
			end else begin
				vx += dx; vy -= dy; acc += longint'(atan_q30(i));
			end
		end
		if (acc < 0) acc = 0;
		if (acc > longint'(Q30_HALF_PI)) acc = longint'(Q30_HALF_PI);
		return acc;
	endfunction

	function automatic logic [15:0] to_q12(longint q);
		longint r;
		r = (q + (64'sd1 << 17)) >>> 18;
		return r[15:0];
	endfunction

	function automatic angles_t solve_joints(target_t t, logic [13:0] u, logic [13:0] w);
		angles_t a;
		longint x, y, z, l1, l2, num, den, elbow, elev, corr, shoulder, wrist, d2;
		longint unsigned an, s, h, ay, ad2;
		x = longint'(t.x); y = longint'(t.y); z = longint'(t.z);
		l1 = longint'(u); l2 = longint'(w);
		num = x * x + y * y + z * z - (l1 * l1 + l2 * l2);
		den = 2 * l1 * l2;
		a = '{shoulder: '0, elbow: '0, wrist: '0, unreachable: 1'b1};
		if (den == 0 || num > den || num < -den) return a;
		while (den < (64'sd1 << 28)) begin
			den *= 2; num *= 2;
		end
		an = num < 0 ? -num : num;
		s = floor_sqrt(den * den - an * an);
		elbow = vector_angle(an, s);
		if (num < 0) elbow = longint'(Q30_PI) - elbow;
		h = floor_sqrt(longint'(x * x + z * z) << 28);
		ay = y < 0 ? -y : y;
		elev = vector_angle(h, ay << 14);
		if (y < 0) elev = -elev;
		d2 = l1 * den + l2 * num;
		ad2 = d2 < 0 ? -d2 : d2;
		corr = vector_angle(ad2, l2 * s);
		if (d2 < 0) corr = -corr;
		shoulder = longint'(Q30_HALF_PI) - elev - corr;
		wrist = longint'(Q30_PI) - (elbow + shoulder);
		a.shoulder = to_q12(shoulder);
		a.elbow = 14'(to_q12(elbow));
		a.wrist = to_q12(wrist);
		a.unreachable = 1'b0;
		return a;
	endfunction

	// Driver: a target item stays on the bus until it is taken.
	always @(negedge clk) begin
		target_t t;
		if (arst_n && (!tgt.valid || target_took)) begin
			if (pending_q.size() > 0 && (steady || $urandom_range(99) >= 25)) begin
				t = pending_q.pop_front();
				tgt.valid <= 1'b1;
				tgt.target_x <= t.x;
				tgt.target_y <= t.y;
				tgt.target_z <= t.z;
			end else tgt.valid <= 1'b0;
		end
	end

	// Receiver with its own long hold-off once requested.
	always @(negedge clk) begin
		int hold;
		if (want_hold) begin
			want_hold = 1'b0;
			hold = 300;
		end
		if (hold > 0) begin
			hold--;
			res.ready <= 1'b0;
		end else if (arst_n)
			res.ready <= steady || $urandom_range(99) >= 25;
	end

	always @(posedge clk) begin
		target_t t;
		angles_t e;
		target_took = tgt.valid && tgt.ready;
		if (target_took) begin
			t = '{x: tgt.target_x, y: tgt.target_y, z: tgt.target_z};
			angles_q.push_back(solve_joints(t, upper_len, lower_len));
		end
		if (res.valid && res.ready) begin
			if (angles_q.size() == 0) begin
				$display("%0t: unexpected result shoulder=%0d elbow=%0d wrist=%0d oor=%b",
					$time, res.shoulder_angle, res.elbow_angle, res.wrist_angle,
					res.out_of_reach);
				errors++;
			end else begin
				e = angles_q.pop_front();
				checked++;
				if (!e.unreachable) reach_cnt++;
				if (res.shoulder_angle !== e.shoulder) begin
					$display("%0t: shoulder_angle expected %0d actual %0d", $time,
						e.shoulder, res.shoulder_angle);
					errors++;
				end
				if (res.elbow_angle !== e.elbow) begin
					$display("%0t: elbow_angle expected %0d actual %0d", $time,
						e.elbow, res.elbow_angle);
					errors++;
				end
				if (res.wrist_angle !== e.wrist) begin
					$display("%0t: wrist_angle expected %0d actual %0d", $time,
						e.wrist, res.wrist_angle);
					errors++;
				end
				if (res.out_of_reach !== e.unreachable) begin
					$display("%0t: out_of_reach expected %b actual %b", $time,
						e.unreachable, res.out_of_reach);
					errors++;
				end
			end
		end
	end

	task automatic drain();
		do @(posedge clk);
		while (pending_q.size() != 0 || tgt.valid || angles_q.size() != 0);
	endtask

	task automatic write_reg(logic [2:0] addr, logic [13:0] value);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= addr; pwdata <= 32'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic set_links(logic [13:0] u, logic [13:0] w);
		write_reg(ADDR_UPPER, u);
		write_reg(ADDR_LOWER, w);
		upper_len = u;
		lower_len = w;
	endtask

	task automatic add_target(int x, int y, int z);
		pending_q.push_back('{x: 15'(x), y: 15'(y), z: 15'(z)});
	endtask

	// Mostly targets inside the working sphere, some anywhere in the field range.
	task automatic add_random(int n);
		int lim;
		lim = (int'(upper_len) + int'(lower_len)) * 4 / 7;
		if (lim > 16383) lim = 16383;
		if (lim < 1) lim = 1;
		repeat (n) begin
			if ($urandom_range(99) < 70)
				add_target($urandom_range(2 * lim) - lim, $urandom_range(2 * lim) - lim,
					$urandom_range(2 * lim) - lim);
			else
				add_target($urandom_range(32767) - 16384, $urandom_range(32767) - 16384,
					$urandom_range(32767) - 16384);
		end
	endtask

	initial begin
		logic [13:0] links[6][2];
		links = '{'{14'd1, 14'd16383}, '{14'd16383, 14'd1}, '{14'd16383, 14'd16383},
			'{14'd0, 14'd6356}, '{14'd8000, 14'd3000}, '{14'd6356, 14'd6356}};
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		tgt.valid = 1'b0; tgt.target_x = '0; tgt.target_y = '0; tgt.target_z = '0;
		res.ready = 1'b0;
		upper_len = LINK_RESET;
		lower_len = LINK_RESET;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed targets with the links at their reset length.
		add_target(0, 0, 0);
		add_target(0, 12712, 0);
		add_target(0, -12712, 0);
		add_target(0, 12713, 0);
		add_target(0, 5000, 0);
		add_target(0, -5000, 0);
		add_target(16383, 16383, 16383);
		add_target(-16384, -16384, -16384);
		add_target(-16384, 0, 0);
		add_target(0, 0, 16383);
		add_target(8988, 0, 8988);
		add_target(6356, 6356, 0);
		add_target(-6356, -6356, 0);
		add_target(1, -1, 1);
		add_target(7000, -3000, -2000);
		add_target(-1200, 9000, 4400);
		drain();

		set_links(14'd6356, 14'd6356);
		add_random(300);
		drain();

		for (int p = 0; p < 6; p++) begin
			set_links(links[p][0], links[p][1]);
			if (p == 3) add_target(0, 0, 0);
			add_random(50);
			if (p == 1) want_hold = 1'b1;
			if (p == 4) steady = 1'b1;
			add_random(200);
			drain();
			steady = 1'b0;
		end
		// Links of 3 and 5 give a zero denominator in the correction term at r^2 = 16.
		set_links(14'd3, 14'd5);
		add_target(0, 4, 0);
		add_target(4, 0, 0);
		add_target(0, -4, 0);
		add_random(40);
		drain();
		repeat (100) @(posedge clk);

		$display("checked %0d results, %0d in reach, over %0d link settings",
			checked, reach_cnt, 8);
		if (errors == 0)
			$display("** two_link_arm_inverse_kinematics: PASSED **");
		else
			$display("** two_link_arm_inverse_kinematics: FAILED **");
		$finish;
	end

endmodule
